FILE: src/ordered_list_insert_delete_search_defines.svh
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared concurrent assertion forms for the ordered list block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define OLIDS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered list check failed");

// Checks that cons holds in the cycle after ante.
`define OLIDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered list check failed");

`endif

FILE: src/olids_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Types and constants shared by the list cells and the list controller.
// ----------------------------------------------------------------------------
package olids_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int COUNT_OUT_W      = 5;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_HEAD   = 2'd0,
      ACT_TAIL   = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_SEARCH = 2'd3
   } action_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Operation broadcast to every cell.
   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_COMPARE = 3'd1,
      CELL_SHIFT   = 3'd2,
      CELL_TAIL    = 3'd3,
      CELL_CLOSE   = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [VALUE_W-1:0]  value;
   } cell_cmd_type;

   // Per-cell position flags derived from the entry count.
   typedef struct packed {
      logic live;
      logic tail;
   } cell_sel_type;

endpackage

FILE: src/ordered_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// Ordered list with insert, delete and search
// Keeps up to CAPACITY signed values in a row of cells, head first.
// ----------------------------------------------------------------------------
// In the cycle a request is accepted all cells compare their entry with the
// value, and in the next cycle the row shifts by one place (insert at head,
// or closing the gap after a delete) or the tail cell takes the value, while
// the response is loaded into the output register. A new request is accepted
// once that register is empty or being taken, and not while the previous
// request is still executing. Delete removes the match nearest the head;
// a full list refuses inserts with the full status.
module ordered_list_insert_delete_search
   import olids_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic signed [31:0]     req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   `include "ordered_list_insert_delete_search_defines.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   state_type          state_ff, state_in;
   action_type         action_ff, action_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               req_accept;
   logic               full;
   logic               found;
   cell_cmd_type       cmd;
   cell_sel_type       sel_w   [CAPACITY];
   logic [VALUE_W-1:0] data_w  [CAPACITY];
   logic               found_w [CAPACITY];

   assign req_stall  = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == CAP_COUNT);
   assign found      = found_w[CAPACITY-1];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Row of list cells, head at index zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic [VALUE_W-1:0] left_data;
      logic [VALUE_W-1:0] right_data;
      logic               found_in;

      assign sel_w[i].live = (IDX < count_ff);
      assign sel_w[i].tail = (IDX == count_ff);

      if (i == 0) begin : g_head
         assign left_data = value_ff;
         assign found_in  = 1'b0;
      end else begin : g_body
         assign left_data = data_w[i-1];
         assign found_in  = found_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = data_w[i];
      end else begin : g_inner
         assign right_data = data_w[i+1];
      end

      olids_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sel        (sel_w[i]),
         .left_data  (left_data),
         .right_data (right_data),
         .found_in   (found_in),
         .data_out   (data_w[i]),
         .found_out  (found_w[i])
      );
   end

   // Sequencer: next state, cell command and response.
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      cmd.op        = CELL_HOLD;
      cmd.value     = value_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               action_in = action_type'(req_action);
               value_in  = req_value;
               cmd.op    = CELL_COMPARE;
               cmd.value = req_value;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_status_in = ST_OK;
            case (action_ff)
               ACT_HEAD: begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     cmd.op   = CELL_SHIFT;
                     count_in = count_ff + CW'(1);
                  end
               end
               ACT_TAIL: begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     cmd.op   = CELL_TAIL;
                     count_in = count_ff + CW'(1);
                  end
               end
               ACT_DELETE: begin
                  if (count_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                  end else if (found) begin
                     cmd.op   = CELL_CLOSE;
                     count_in = count_ff - CW'(1);
                  end else begin
                     rsp_status_in = ST_MISSING;
                  end
               end
               default: begin
                  rsp_status_in = found ? ST_OK : ST_MISSING;
               end
            endcase
            rsp_count_in = COUNT_OUT_W'(count_in);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Consistency checks on the sequencer and entry count.
   `OLIDS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CAP_COUNT)
   `OLIDS_ASSERT_NEXT(a_accept_exec, req_accept, state_ff == S_EXEC)
   `OLIDS_ASSERT_NOW(a_exec_slot_free, state_ff == S_EXEC, !rsp_valid_ff)
   `OLIDS_ASSERT_NEXT(a_exec_responds, state_ff == S_EXEC, rsp_valid_ff)
   `OLIDS_ASSERT_NEXT(a_count_only_exec, state_ff == S_IDLE, $stable(count_ff))

endmodule

FILE: src/olids_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list position, compares it with the request value, moves data to
// or from its neighbors on head insert and delete, and loads the value on a tail insert.
// ----------------------------------------------------------------------------
module olids_cell
   import olids_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_cmd_type       cmd,
   input  cell_sel_type       sel,
   input  logic [VALUE_W-1:0] left_data,
   input  logic [VALUE_W-1:0] right_data,
   input  logic               found_in,
   output logic [VALUE_W-1:0] data_out,
   output logic               found_out
);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               match_ff;
   logic               match_in;

   // A match here or nearer the head marks this cell as part of the closing shift.
   assign found_out = found_in | match_ff;
   assign data_out  = data_ff;

   // Next entry value and match flag.
   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      case (cmd.op)
         CELL_COMPARE: begin
            match_in = sel.live && (data_ff == cmd.value);
         end
         CELL_SHIFT: begin
            data_in = left_data;
         end
         CELL_TAIL: begin
            if (sel.tail) begin
               data_in = cmd.value;
            end
         end
         CELL_CLOSE: begin
            if (found_out) begin
               data_in = right_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

FILE: verif/ordered_list_insert_delete_search_test.sv
// ----------------------------------------------------------------------------
// Ordered list testbench
// Drives insert, delete and search requests into the ordered list, keeps its
// own copy of the list to work out each response, and checks every response
// field by field under random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ordered_list_insert_delete_search_test;
   import olids_pkg::*;

   localparam int LIST_DEPTH   = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1525;
   localparam int QUIET_ITEMS  = 200;
   localparam int CHUNK_ITEMS  = 60;

   typedef struct {
      status_type               status;
      logic [COUNT_OUT_W-1:0]   count;
   } list_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_action = ACT_SEARCH;
   logic signed [31:0]     req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   // Expected contents of the list, head first, and the responses still owed.
   logic [31:0]     list_copy[$];
   list_result_type pending_results[$];

   int fail_count   = 0;
   int cycle_count  = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int stall_left     = 0;
   logic [31:0] value_pool [8];

   ordered_list_insert_delete_search uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always #10 clock = ~clock;

   // Applies one request to the list copy and returns the response it causes.
   function automatic list_result_type apply_list_request(input action_type act,
                                                          input logic [31:0] val);
      list_result_type res;
      int hit;
      res.status = ST_OK;
      hit = -1;
      for (int i = 0; i < list_copy.size(); i++) begin
         if (hit < 0 && list_copy[i] == val) begin
            hit = i;
         end
      end
      case (act)
         ACT_HEAD, ACT_TAIL: begin
            if (list_copy.size() >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else if (act == ACT_HEAD) begin
               list_copy.push_front(val);
            end else begin
               list_copy.push_back(val);
            end
         end
         ACT_DELETE: begin
            if (list_copy.size() == 0) begin
               res.status = ST_EMPTY;
            end else if (hit < 0) begin
               res.status = ST_MISSING;
            end else begin
               list_copy.delete(hit);
            end
         end
         default: begin
            res.status = (hit >= 0) ? ST_OK : ST_MISSING;
         end
      endcase
      res.count = COUNT_OUT_W'(list_copy.size());
      return res;
   endfunction

   // Checks responses first, since a response never belongs to a request
   // accepted at the same edge, then records the newly accepted request.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding: status %0d, count %0d",
                      rsp_status, rsp_entry_count);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("rsp_entry_count mismatch: expected %0d, actual %0d",
                         want.count, rsp_entry_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(apply_list_request(action_type'(req_action),
                                                         req_value));
         end
      end
   end

   // Response side stalls in bursts of random length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         stall_left = $urandom_range(2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Presents one request, after an optional idle burst, and holds it until
   // it is accepted.
   task automatic send_request(input action_type act, input logic [31:0] val);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic test_empty_list();
      send_request(ACT_DELETE, 32'h0000_0000);
      send_request(ACT_SEARCH, 32'hFFFF_FFFF);
   endtask

   // Fills the list with extreme and duplicate values from both ends, then
   // tries to insert past capacity.
   task automatic test_fill_to_capacity();
      logic [31:0] fill_vals [16] = '{
         32'h0000_0005, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005,
         32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h5555_5555,
         32'hAAAA_AAAA, 32'h0000_0002, 32'h8000_0001, 32'h7FFF_FFFE,
         32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0005, 32'hDEAD_BEEF};
      for (int i = 0; i < 16; i++) begin
         send_request(i[0] ? ACT_TAIL : ACT_HEAD, fill_vals[i]);
      end
      send_request(ACT_HEAD, 32'h1234_5678);
      send_request(ACT_TAIL, 32'h1234_5678);
   endtask

   // Search hit and miss, duplicate delete nearest the head, absent delete.
   task automatic test_delete_and_search();
      send_request(ACT_SEARCH, 32'h8000_0000);
      send_request(ACT_SEARCH, 32'h1234_5678);
      send_request(ACT_DELETE, 32'h0000_0005);
      send_request(ACT_SEARCH, 32'h0000_0005);
      send_request(ACT_DELETE, 32'h1234_5678);
   endtask

   // Mostly values from a small pool so that deletes and searches hit,
   // with extremes and fully random values mixed in.
   function automatic logic [31:0] pick_list_value();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5, 6: return value_pool[$urandom_range(7)];
         7: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Random traffic in chunks that grow, churn or shrink the list so that it
   // swings between empty and full, with idling varied per chunk.
   task automatic test_random_traffic();
      action_type act;
      int insert_pct;
      int delete_pct;
      int roll;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % CHUNK_ITEMS == 0) begin
            for (int k = 0; k < 8; k++) begin
               value_pool[k] = $urandom;
            end
            case ((n / CHUNK_ITEMS) % 3)
               0: begin
                  insert_pct = 75;
                  delete_pct = 15;
               end
               1: begin
                  insert_pct = 40;
                  delete_pct = 35;
               end
               default: begin
                  insert_pct = 15;
                  delete_pct = 70;
               end
            endcase
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end else begin
               send_idle_pct = 25 * $urandom_range(2);
               rsp_stall_pct = 25 * $urandom_range(2);
            end
         end
         roll = $urandom_range(99);
         if (roll < insert_pct) begin
            act = ($urandom_range(1) != 0) ? ACT_TAIL : ACT_HEAD;
         end else if (roll < insert_pct + delete_pct) begin
            act = ACT_DELETE;
         end else begin
            act = ACT_SEARCH;
         end
         send_request(act, pick_list_value());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      rsp_stall_pct = 30;
      test_empty_list();
      test_fill_to_capacity();
      test_delete_and_search();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/olids_pkg.sv
src/olids_cell.sv
src/ordered_list_insert_delete_search.sv
verif/ordered_list_insert_delete_search_test.sv
